// ===== design/rmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmbd_pkg
// Shared types, codes and helpers of the radar moment block decoder.
// ----------------------------------------------------------------------------
package rmbd_pkg;

    localparam int unsigned GATE_MAX     = 2048;
    localparam int unsigned HEADER_BYTES = 28;

    localparam logic [31:0] NM_RVOL = 32'h52564F4C;
    localparam logic [31:0] NM_RELV = 32'h52454C56;
    localparam logic [31:0] NM_RRAD = 32'h52524144;
    localparam logic [31:0] NM_DREF = 32'h44524546;
    localparam logic [31:0] NM_DVEL = 32'h4456454C;
    localparam logic [23:0] NM_DSW3 = 24'h445357;
    localparam logic [31:0] NM_DZDR = 32'h445A4452;
    localparam logic [31:0] NM_DPHI = 32'h44504849;
    localparam logic [31:0] NM_DRHO = 32'h4452484F;

    localparam logic [31:0] Q_MAX   = 32'h7FFFFFFF;
    localparam logic [31:0] Q_MIN   = 32'h80000000;
    localparam logic [31:0] BAD_Q16 = 32'hD8F10000;

    localparam logic [2:0] NUMBER_NONE = 3'd7;

    localparam logic [3:0] KIND_GATE     = 4'd0;
    localparam logic [3:0] KIND_HEADER   = 4'd1;
    localparam logic [3:0] KIND_VOLUME   = 4'd2;
    localparam logic [3:0] KIND_ELEV     = 4'd3;
    localparam logic [3:0] KIND_RADIAL   = 4'd4;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd5;
    localparam logic [3:0] KIND_BITSIZE  = 4'd6;
    localparam logic [3:0] KIND_COMPRESS = 4'd7;
    localparam logic [3:0] KIND_TOOMANY  = 4'd8;

    localparam logic [3:0] FC_UNKNOWN = 4'd0;
    localparam logic [3:0] FC_VOL     = 4'd1;
    localparam logic [3:0] FC_ELV     = 4'd2;
    localparam logic [3:0] FC_RAD     = 4'd3;
    localparam logic [3:0] FC_DBZ     = 4'd4;

    localparam logic ADDR_WANT_MASK   = 1'b0;
    localparam logic ADDR_COMPRESSION = 1'b1;

    typedef struct packed {
        logic               last;
        logic [31:0]        lon_bits;
        logic [31:0]        lat_bits;
        logic signed [15:0] info_c;
        logic signed [17:0] info_b;
        logic [15:0]        info_a;
        logic               gate_valid;
        logic signed [31:0] gate_value;
        logic [10:0]        gate_index;
        logic signed [3:0]  field_number;
        logic [3:0]         field_code;
        logic [3:0]         kind;
    } res_t;

    typedef struct packed {
        logic               start;
        logic signed [33:0] num;
        logic signed [31:0] den;
    } div_req_t;

    function automatic logic [31:0] float_to_q16(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  e;
        logic [23:0] mant;
        logic [31:0] mag;
        logic [4:0]  n;
        logic [24:0] rnd;
        neg  = bits[31];
        e    = bits[30:23];
        mant = {1'b1, bits[22:0]};
        mag  = '0;
        n    = 5'(8'd134 - e);
        rnd  = '0;
        if (e == 8'hFF) begin
            if (bits[22:0] != '0) return '0;
            return neg ? Q_MIN : Q_MAX;
        end
        if (e == 8'h00) return '0;
        if (e >= 8'd142) return neg ? Q_MIN : Q_MAX;
        if (e >= 8'd134) begin
            mag = 32'(mant) << 3'(e - 8'd134);
        end else if (e > 8'd108) begin
            rnd = 25'(mant) + (25'd1 << (n - 5'd1));
            mag = 32'(rnd >> n);
        end
        return neg ? (32'd0 - mag) : mag;
    endfunction

endpackage

// ===== design/rmbd_divider.sv =====
// ----------------------------------------------------------------------------
// rmbd_divider
// Shared Q16.16 divider, two quotient bits per cycle, rounded and saturated.
// ----------------------------------------------------------------------------
module rmbd_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  rmbd_pkg::div_req_t  req,
    output logic                done,
    output logic [31:0]         quo
);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN, DV_DONE} dv_state_t;

    dv_state_t   state_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] ad_reg;
    logic        neg_reg;
    logic        ovf_reg;
    logic        zero_reg;
    logic        nneg_reg;
    logic        npos_reg;
    logic [31:0] quo_reg;

    logic [33:0] an;
    logic [31:0] ad;
    logic [32:0] sh1;
    logic [32:0] sh2;
    logic [31:0] rem1;
    logic [31:0] rem_next;
    logic [31:0] low_next;
    logic        q1;
    logic        q2;
    logic        rnd;
    logic [32:0] q33;
    logic [31:0] res;

    always_comb begin
        an  = req.num[33] ? 34'(-req.num) : req.num;
        ad  = req.den[31] ? 32'(-req.den) : req.den;
        sh1 = {rem_reg, low_reg[31]};
        q1  = sh1 >= {1'b0, ad_reg};
        rem1 = q1 ? 32'(sh1 - {1'b0, ad_reg}) : sh1[31:0];
        sh2 = {rem1, low_reg[30]};
        q2  = sh2 >= {1'b0, ad_reg};
        rem_next = q2 ? 32'(sh2 - {1'b0, ad_reg}) : sh2[31:0];
        low_next = {low_reg[29:0], q1, q2};
        rnd = {rem_reg, 1'b0} >= {1'b0, ad_reg};
        q33 = {1'b0, low_reg} + 33'(rnd);
        if (zero_reg) begin
            res = npos_reg ? rmbd_pkg::Q_MAX : (nneg_reg ? rmbd_pkg::Q_MIN : '0);
        end else if (ovf_reg) begin
            res = neg_reg ? rmbd_pkg::Q_MIN : rmbd_pkg::Q_MAX;
        end else if (neg_reg) begin
            res = (q33 > 33'h080000000) ? rmbd_pkg::Q_MIN : 32'(33'd0 - q33);
        end else begin
            res = (q33 > 33'h07FFFFFFF) ? rmbd_pkg::Q_MAX : q33[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end else if (req.start) begin
            state_reg <= DV_RUN;
            cnt_reg   <= 4'd15;
            rem_reg   <= {14'd0, an[33:16]};
            low_reg   <= {an[15:0], 16'd0};
            ad_reg    <= ad;
            neg_reg   <= req.num[33] ^ req.den[31];
            ovf_reg   <= {14'd0, an[33:16]} >= ad;
            zero_reg  <= ad == '0;
            nneg_reg  <= req.num[33];
            npos_reg  <= !req.num[33] && (an != '0);
        end else begin
            case (state_reg)
                DV_RUN: begin
                    rem_reg <= rem_next;
                    low_reg <= low_next;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0) state_reg <= DV_FIN;
                end
                DV_FIN: begin
                    quo_reg   <= res;
                    state_reg <= DV_DONE;
                end
                default: ;
            endcase
        end
    end

    assign done = state_reg == DV_DONE;
    assign quo  = quo_reg;

endmodule

// ===== design/radar_moment_block_decoder.sv =====
// ----------------------------------------------------------------------------
// radar_moment_block_decoder
// Byte-serial decoder of radar data blocks: names, headers and moment gates.
// ----------------------------------------------------------------------------
// A byte with no valid gate is taken and answered via the output register.
// A valid gate passes the divider start, 16 steps of the shared radix-4
// divider, a rounding step and the output load, which waits for a free
// output; one byte in flight at a time. Reset (aresetn low, synchronous)
// restores register defaults and ignores bytes until the next block start.
module radar_moment_block_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // block_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // field_code, field_number, gate_index, gate_value, gate_valid,
    // info_a, info_b, info_c, lat_bits, lon_bits
    output logic [167:0] m_tdata,
    output logic [3:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic {ST_IDLE, ST_DIV} state_t;

    state_t          state_reg, state_next;
    logic [5:0]      want_reg;
    logic [1:0]      comp_reg;
    logic [15:0]     byte_count_reg, byte_count_next;
    logic [31:0]     name_word_reg, name_word_next;
    logic [3:0]      block_field_reg, block_field_next;
    logic [2:0]      block_number_reg, block_number_next;
    logic            skipping_reg, skipping_next;
    logic [15:0]     gate_total_reg, gate_total_next;
    logic [15:0]     first_range_reg, first_range_next;
    logic [15:0]     spacing_reg, spacing_next;
    logic [7:0]      bit_size_reg, bit_size_next;
    logic [31:0]     scale_reg, scale_next;
    logic [31:0]     bias_reg, bias_next;
    logic [63:0]     hold_reg, hold_next;
    logic [7:0]      ghb_reg, ghb_next;
    logic [15:0]     gate_count_reg, gate_count_next;
    logic            half_reg, half_next;
    rmbd_pkg::res_t  pend_reg, pend_next;
    rmbd_pkg::res_t  out_reg, out_next;
    logic            m_valid_reg;
    logic            out_load;

    rmbd_pkg::div_req_t div_req;
    logic               div_done;
    logic [31:0]        div_quo;

    logic        s_fire;
    logic        cfg_wr;
    logic [7:0]  b;
    logic [15:0] pos;
    logic [31:0] nm;
    logic        e_hit;
    logic        e_gate;
    logic        e_div;
    logic [3:0]  e_kind;
    logic        e_last;
    logic [15:0] e_a;
    logic [17:0] e_b;
    logic [15:0] e_c;
    logic [31:0] e_lat;
    logic [31:0] e_lon;
    logic [31:0] e_val;
    logic        e_valid;
    logic        mom_hit;
    logic [2:0]  mom_idx;
    logic [2:0]  mom_pos;
    logic [15:0] raw;
    logic        gate_do;

    rmbd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == rmbd_pkg::ADDR_COMPRESSION) ? {30'd0, comp_reg}
                                                              : {26'd0, want_reg};

    always_comb begin
        state_next        = state_reg;
        byte_count_next   = byte_count_reg;
        name_word_next    = name_word_reg;
        block_field_next  = block_field_reg;
        block_number_next = block_number_reg;
        skipping_next     = skipping_reg;
        gate_total_next   = gate_total_reg;
        first_range_next  = first_range_reg;
        spacing_next      = spacing_reg;
        bit_size_next     = bit_size_reg;
        scale_next        = scale_reg;
        bias_next         = bias_reg;
        hold_next         = hold_reg;
        ghb_next          = ghb_reg;
        gate_count_next   = gate_count_reg;
        half_next         = half_reg;
        pend_next         = pend_reg;
        out_next          = out_reg;
        out_load          = 1'b0;
        div_req           = '0;
        pos     = byte_count_reg;
        nm      = {name_word_reg[23:0], b};
        e_hit   = 1'b0;
        e_gate  = 1'b0;
        e_div   = 1'b0;
        e_kind  = rmbd_pkg::KIND_GATE;
        e_last  = 1'b0;
        e_a     = '0;
        e_b     = '0;
        e_c     = '0;
        e_lat   = '0;
        e_lon   = '0;
        e_val   = '0;
        e_valid = 1'b0;
        mom_hit = 1'b1;
        mom_idx = '0;
        mom_pos = '0;
        raw     = '0;
        gate_do = 1'b0;

        if (nm == rmbd_pkg::NM_DREF)           mom_idx = 3'd0;
        else if (nm == rmbd_pkg::NM_DVEL)      mom_idx = 3'd1;
        else if (nm[31:8] == rmbd_pkg::NM_DSW3) mom_idx = 3'd2;
        else if (nm == rmbd_pkg::NM_DZDR)      mom_idx = 3'd3;
        else if (nm == rmbd_pkg::NM_DPHI)      mom_idx = 3'd4;
        else if (nm == rmbd_pkg::NM_DRHO)      mom_idx = 3'd5;
        else                                   mom_hit = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (3'(k) < mom_idx && want_reg[k]) mom_pos = mom_pos + 3'd1;
        end

        if (s_fire) begin
            if (s_tuser) begin
                byte_count_next   = 16'd1;
                name_word_next    = {24'd0, b};
                block_field_next  = rmbd_pkg::FC_UNKNOWN;
                block_number_next = rmbd_pkg::NUMBER_NONE;
                skipping_next     = 1'b0;
                gate_total_next   = '0;
                first_range_next  = '0;
                spacing_next      = '0;
                bit_size_next     = '0;
                scale_next        = '0;
                bias_next         = '0;
                hold_next         = '0;
                ghb_next          = '0;
                gate_count_next   = '0;
                half_next         = 1'b0;
            end else if (!skipping_reg) begin
                if (byte_count_reg != 16'hFFFF) byte_count_next = byte_count_reg + 16'd1;
                if (pos < 16'd4) begin
                    name_word_next = nm;
                    if (pos == 16'd3) begin
                        if (nm == rmbd_pkg::NM_RVOL) begin
                            block_field_next = rmbd_pkg::FC_VOL;
                        end else if (nm == rmbd_pkg::NM_RRAD) begin
                            block_field_next = rmbd_pkg::FC_RAD;
                        end else if (nm == rmbd_pkg::NM_RELV) begin
                            block_field_next = rmbd_pkg::FC_ELV;
                            e_hit = 1'b1; e_kind = rmbd_pkg::KIND_ELEV; e_last = 1'b1;
                        end else if (!mom_hit) begin
                            block_field_next = rmbd_pkg::FC_UNKNOWN;
                            e_hit = 1'b1; e_kind = rmbd_pkg::KIND_UNKNOWN; e_last = 1'b1;
                        end else begin
                            block_field_next = rmbd_pkg::FC_DBZ + 4'(mom_idx);
                            if (want_reg[mom_idx]) begin
                                block_number_next = mom_pos;
                            end else begin
                                block_number_next = rmbd_pkg::NUMBER_NONE;
                                e_hit = 1'b1; e_kind = rmbd_pkg::KIND_HEADER; e_last = 1'b1;
                            end
                        end
                    end
                end else if (block_field_reg == rmbd_pkg::FC_VOL) begin
                    if (pos >= 16'd8 && pos <= 16'd15) hold_next = {hold_reg[55:0], b};
                    else if (pos == 16'd16 || pos == 16'd17)
                        first_range_next = {first_range_reg[7:0], b};
                    else if (pos == 16'd18 || pos == 16'd19)
                        spacing_next = {spacing_reg[7:0], b};
                    else if (pos == 16'd40) ghb_next = b;
                    else if (pos == 16'd41) begin
                        e_hit = 1'b1; e_kind = rmbd_pkg::KIND_VOLUME; e_last = 1'b1;
                        e_a   = {ghb_reg, b};
                        e_b   = 18'(signed'(first_range_reg)) + {2'd0, spacing_reg};
                        e_lat = hold_reg[63:32];
                        e_lon = hold_reg[31:0];
                    end
                end else if (block_field_reg == rmbd_pkg::FC_RAD) begin
                    if (pos == 16'd16) ghb_next = b;
                    else if (pos == 16'd17) begin
                        e_hit = 1'b1; e_kind = rmbd_pkg::KIND_RADIAL; e_last = 1'b1;
                        e_a   = {ghb_reg, b};
                    end
                end else if (block_field_reg >= rmbd_pkg::FC_DBZ) begin
                    if (pos < 16'(rmbd_pkg::HEADER_BYTES)) begin
                        if (pos == 16'd8 || pos == 16'd9)
                            gate_total_next = {gate_total_reg[7:0], b};
                        else if (pos == 16'd10 || pos == 16'd11)
                            first_range_next = {first_range_reg[7:0], b};
                        else if (pos == 16'd12 || pos == 16'd13)
                            spacing_next = {spacing_reg[7:0], b};
                        else if (pos == 16'd19) bit_size_next = b;
                        else if (pos >= 16'd20) hold_next = {hold_reg[55:0], b};
                        if (pos == 16'(rmbd_pkg::HEADER_BYTES - 1)) begin
                            scale_next = rmbd_pkg::float_to_q16(hold_next[63:32]);
                            bias_next  = rmbd_pkg::float_to_q16(hold_next[31:0]);
                            e_hit  = 1'b1;
                            e_last = 1'b1;
                            if (comp_reg != '0) e_kind = rmbd_pkg::KIND_COMPRESS;
                            else if (bit_size_reg != 8'd8 && bit_size_reg != 8'd16)
                                e_kind = rmbd_pkg::KIND_BITSIZE;
                            else if (gate_total_reg > 16'(rmbd_pkg::GATE_MAX))
                                e_kind = rmbd_pkg::KIND_TOOMANY;
                            else begin
                                e_kind = rmbd_pkg::KIND_HEADER;
                                e_last = gate_total_reg == '0;
                                e_a    = gate_total_reg;
                                e_b    = 18'(signed'(first_range_reg));
                                e_c    = spacing_reg;
                            end
                        end
                    end else if (bit_size_reg == 8'd16) begin
                        if (!half_reg) begin
                            ghb_next  = b;
                            half_next = 1'b1;
                        end else begin
                            half_next = 1'b0;
                            raw       = {ghb_reg, b};
                            gate_do   = 1'b1;
                        end
                    end else begin
                        raw     = {8'd0, b};
                        gate_do = 1'b1;
                    end
                end
                if (gate_do) begin
                    e_hit   = 1'b1;
                    e_gate  = 1'b1;
                    e_kind  = rmbd_pkg::KIND_GATE;
                    e_last  = ({1'b0, gate_count_reg} + 17'd1) >= {1'b0, gate_total_reg};
                    e_valid = raw > 16'd1;
                    e_val   = rmbd_pkg::BAD_Q16;
                    e_div   = e_valid;
                    gate_count_next = gate_count_reg + 16'd1;
                end
            end
        end

        if (e_hit) begin
            out_next              = '0;
            out_next.kind         = e_kind;
            out_next.field_code   = block_field_next;
            out_next.field_number = (block_number_next == rmbd_pkg::NUMBER_NONE) ?
                                    -4'sd1 : signed'({1'b0, block_number_next});
            out_next.gate_index   = e_gate ? gate_count_reg[10:0] : '0;
            out_next.gate_value   = e_val;
            out_next.gate_valid   = e_valid;
            out_next.info_a       = e_a;
            out_next.info_b       = e_b;
            out_next.info_c       = e_c;
            out_next.lat_bits     = e_lat;
            out_next.lon_bits     = e_lon;
            out_next.last         = e_last;
            if (e_last) skipping_next = 1'b1;
            if (e_div) begin
                pend_next     = out_next;
                out_next      = out_reg;
                state_next    = ST_DIV;
                div_req.start = 1'b1;
                div_req.num   = signed'({2'd0, raw, 16'd0}) - 34'(signed'(bias_reg));
                div_req.den   = signed'(scale_reg);
            end else begin
                out_load = 1'b1;
            end
        end

        if (state_reg == ST_DIV && div_done && (!m_valid_reg || m_tready)) begin
            out_next            = pend_reg;
            out_next.gate_value = div_quo;
            out_load            = 1'b1;
            state_next          = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            want_reg         <= 6'd63;
            comp_reg         <= '0;
            m_valid_reg      <= 1'b0;
            byte_count_reg   <= '0;
            name_word_reg    <= '0;
            block_field_reg  <= '0;
            block_number_reg <= rmbd_pkg::NUMBER_NONE;
            skipping_reg     <= 1'b1;
            gate_total_reg   <= '0;
            first_range_reg  <= '0;
            spacing_reg      <= '0;
            bit_size_reg     <= '0;
            scale_reg        <= '0;
            bias_reg         <= '0;
            hold_reg         <= '0;
            ghb_reg          <= '0;
            gate_count_reg   <= '0;
            half_reg         <= 1'b0;
        end else begin
            state_reg        <= state_next;
            byte_count_reg   <= byte_count_next;
            name_word_reg    <= name_word_next;
            block_field_reg  <= block_field_next;
            block_number_reg <= block_number_next;
            skipping_reg     <= skipping_next;
            gate_total_reg   <= gate_total_next;
            first_range_reg  <= first_range_next;
            spacing_reg      <= spacing_next;
            bit_size_reg     <= bit_size_next;
            scale_reg        <= scale_next;
            bias_reg         <= bias_next;
            hold_reg         <= hold_next;
            ghb_reg          <= ghb_next;
            gate_count_reg   <= gate_count_next;
            half_reg         <= half_next;
            if (cfg_wr) begin
                if (paddr[2] == rmbd_pkg::ADDR_WANT_MASK) want_reg <= pwdata[5:0];
                else comp_reg <= pwdata[1:0];
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
        pend_reg <= pend_next;
        if (out_load) out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'd0, out_reg.lon_bits, out_reg.lat_bits, out_reg.info_c,
                       out_reg.info_b, out_reg.info_a, out_reg.gate_valid,
                       out_reg.gate_value, out_reg.gate_index, out_reg.field_number,
                       out_reg.field_code};

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> !s_tready)
        else $error("input taken while a gate division is in flight");

    a_last_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_next.last |=> skipping_reg)
        else $error("block not closed after final transaction");

    a_valid_is_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[51] |-> m_tuser == rmbd_pkg::KIND_GATE)
        else $error("gate_valid set on a non-gate transaction");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> state_reg == ST_IDLE)
        else $error("divider restarted while busy");

endmodule
